>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// is held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a property holds at every rising edge of clk_i.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Check that a condition is never true at a rising edge of clk_i.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> sv/cmc_pkg.sv
`default_nettype none

package cmc_pkg;

  // Field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CEN_W   = 10;
  localparam int unsigned SUM_W   = 30;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned STEP_W  = 5;

  // Saturation limits of the running sums and the hit count
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Last step of a dividend-wide restoring division
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_REF_HUE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_SAT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW = 2'd2;

  // Register values after reset
  localparam logic [CFG_W-1:0] REF_HUE_RST      = 8'd255;
  localparam logic [CFG_W-1:0] REF_SAT_RST      = 8'd100;
  localparam logic [CFG_W-1:0] MATCH_WINDOW_RST = 8'd50;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_DONE
  } state_e;

  // True when value lies strictly inside (ref - half, ref + half).
  function automatic logic in_window(input logic [PIX_W-1:0] value,
                                     input logic [PIX_W-1:0] ref_val,
                                     input logic [PIX_W-2:0] half);
    logic signed [PIX_W+1:0] v;
    logic signed [PIX_W+1:0] lo;
    logic signed [PIX_W+1:0] hi;
    v  = $signed({2'b00, value});
    lo = $signed({2'b00, ref_val}) - $signed({3'b000, half});
    hi = $signed({2'b00, ref_val}) + $signed({3'b000, half});
    return (v > lo) && (v < hi);
  endfunction

endpackage

`default_nettype wire

>>> sv/cmc_if.sv
`default_nettype none

// Pixel channel: one HSV pixel with its raster marks per transaction.
interface cmc_pix_if;
  logic                        valid;
  logic                        ready;
  logic [cmc_pkg::PIX_W-1:0]   pix_hue;
  logic [cmc_pkg::PIX_W-1:0]   pix_sat;
  logic                        line_end;
  logic                        frame_end;

  modport source (output valid, pix_hue, pix_sat, line_end, frame_end, input ready);
  modport sink   (input valid, pix_hue, pix_sat, line_end, frame_end, output ready);
endinterface

// Result channel: mask bit per pixel, centroid on the frame's last pixel.
interface cmc_res_if;
  logic                        valid;
  logic                        ready;
  logic                        mask_bit;
  logic                        centroid_valid;
  logic [cmc_pkg::CEN_W-1:0]   centroid_col;
  logic [cmc_pkg::CEN_W-1:0]   centroid_row;
  logic [cmc_pkg::CNT_W-1:0]   match_count;

  modport source (output valid, mask_bit, centroid_valid, centroid_col, centroid_row,
                  match_count, input ready);
  modport sink   (input valid, mask_bit, centroid_valid, centroid_col, centroid_row,
                  match_count, output ready);
endinterface

`default_nettype wire

>>> sv/color_mask_centroid.sv
// Colour-mask centroid tracker.
// pix_i carries one HSV pixel per transaction in raster order, with line_end
// and frame_end marks; res_o returns one result per pixel: the mask bit, and
// on the frame's last pixel the centroid (column and row sums divided by the
// hit count, 0 when no pixel matched) and the hit count.
// Configuration (ref_hue, ref_sat, match_window) is written through cfg_we_i /
// cfg_idx_i / cfg_data_i; the user must write it only while the block is idle,
// which the block itself does not enforce. A result is registered in the cycle
// after its pixel is taken; a frame-end pixel's result once ST_DONE finds the
// output register free. Throughput: one pixel per cycle inside a frame while
// the output register drains. A frame-end pixel runs a shared one-bit-per-cycle
// restoring divider twice (column, then row), 30 steps each, then loads the
// result in ST_DONE; only then is the next pixel taken.
// Stalls: the output register drains while a new pixel is taken; when
// res_o.ready stays low and the register is full, pix_i.ready drops.
// Reset: position, sums and count clear, registers return to
// ref_hue=255, ref_sat=100, match_window=50, output register empties.
`default_nettype none

`include "assert_macros.svh"

module color_mask_centroid #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cmc_pkg::CFG_W-1:0]      cfg_data_i,
  cmc_pix_if.sink                             pix_i,
  cmc_res_if.source                           res_o
);

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

  // Configuration registers
  logic [cmc_pkg::CFG_W-1:0] ref_hue_q, ref_sat_q, match_window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_hue_q      <= cmc_pkg::REF_HUE_RST;
      ref_sat_q      <= cmc_pkg::REF_SAT_RST;
      match_window_q <= cmc_pkg::MATCH_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmc_pkg::REG_REF_HUE:      ref_hue_q      <= cfg_data_i;
        cmc_pkg::REG_REF_SAT:      ref_sat_q      <= cfg_data_i;
        cmc_pkg::REG_MATCH_WINDOW: match_window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmc_pkg::state_e state_q, state_d;
  logic [CW-1:0]                   col_pos_q, col_pos_d;
  logic [RW-1:0]                   row_pos_q, row_pos_d;
  logic [cmc_pkg::SUM_W-1:0]       col_sum_q, col_sum_d;
  logic [cmc_pkg::SUM_W-1:0]       row_sum_q, row_sum_d;
  logic [cmc_pkg::CNT_W-1:0]       hit_count_q, hit_count_d;
  logic [cmc_pkg::CNT_W-1:0]       rem_q, rem_d;
  logic [cmc_pkg::SUM_W-1:0]       dvd_q, dvd_d;
  logic [cmc_pkg::STEP_W-1:0]      step_q, step_d;
  logic [cmc_pkg::CEN_W-1:0]       cx_q, cx_d;
  logic [cmc_pkg::CEN_W-1:0]       cy_q, cy_d;
  logic                            pend_mask_q, pend_mask_d;

  logic                            ovalid_q, ovalid_d;
  logic                            omask_q, omask_d;
  logic                            ocval_q, ocval_d;
  logic [cmc_pkg::CEN_W-1:0]       ocol_q, ocol_d;
  logic [cmc_pkg::CEN_W-1:0]       orow_q, orow_d;
  logic [cmc_pkg::CNT_W-1:0]       ocnt_q, ocnt_d;

  logic out_free;
  logic in_acc;
  logic hit;
  logic [cmc_pkg::SUM_W:0]   col_add, row_add;
  logic [cmc_pkg::CNT_W:0]   rem_sh;
  logic [cmc_pkg::CNT_W+1:0] diff;
  logic                      take;
  logic [cmc_pkg::CNT_W-1:0] rem_nxt;
  logic                      cnt_zero;

  assign out_free    = !ovalid_q || res_o.ready;
  assign pix_i.ready = (state_q == cmc_pkg::ST_RUN) && out_free;
  assign in_acc      = pix_i.valid && pix_i.ready;

  // Window test on hue and saturation
  assign hit = cmc_pkg::in_window(pix_i.pix_hue, ref_hue_q, match_window_q[7:1]) &&
               cmc_pkg::in_window(pix_i.pix_sat, ref_sat_q, match_window_q[7:1]);

  // Saturating accumulate of the masked position
  assign col_add = {1'b0, col_sum_q} + (cmc_pkg::SUM_W + 1)'(col_pos_q);
  assign row_add = {1'b0, row_sum_q} + (cmc_pkg::SUM_W + 1)'(row_pos_q);

  // Shared restoring divider step: one quotient bit per cycle
  assign rem_sh   = {rem_q, dvd_q[cmc_pkg::SUM_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, hit_count_q};
  assign take     = !diff[cmc_pkg::CNT_W+1];
  assign rem_nxt  = take ? diff[cmc_pkg::CNT_W-1:0] : rem_sh[cmc_pkg::CNT_W-1:0];
  assign cnt_zero = (hit_count_q == '0);

  // Sequencer: next state, accumulators, divider and output register
  always_comb begin
    state_d     = state_q;
    col_pos_d   = col_pos_q;
    row_pos_d   = row_pos_q;
    col_sum_d   = col_sum_q;
    row_sum_d   = row_sum_q;
    hit_count_d = hit_count_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    step_d      = step_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    pend_mask_d = pend_mask_q;
    omask_d     = omask_q;
    ocval_d     = ocval_q;
    ocol_d      = ocol_q;
    orow_d      = orow_q;
    ocnt_d      = ocnt_q;
    ovalid_d    = res_o.ready ? 1'b0 : ovalid_q;

    case (state_q)
      cmc_pkg::ST_RUN: begin
        if (in_acc) begin
          if (hit) begin
            col_sum_d   = col_add[cmc_pkg::SUM_W] ? cmc_pkg::SUM_MAX
                                                  : col_add[cmc_pkg::SUM_W-1:0];
            row_sum_d   = row_add[cmc_pkg::SUM_W] ? cmc_pkg::SUM_MAX
                                                  : row_add[cmc_pkg::SUM_W-1:0];
            hit_count_d = (hit_count_q == cmc_pkg::CNT_MAX) ? hit_count_q
                                                            : hit_count_q + 1'b1;
          end
          if (pix_i.frame_end) begin
            // hold the mask bit and start dividing the column sum
            pend_mask_d = hit;
            dvd_d       = col_sum_d;
            rem_d       = '0;
            step_d      = '0;
            state_d     = cmc_pkg::ST_DIV_COL;
          end else begin
            ovalid_d = 1'b1;
            omask_d  = hit;
            ocval_d  = 1'b0;
            ocol_d   = '0;
            orow_d   = '0;
            ocnt_d   = '0;
            if (pix_i.line_end) begin
              col_pos_d = '0;
              if (row_pos_q != ROW_LAST) begin
                row_pos_d = row_pos_q + 1'b1;
              end
            end else if (col_pos_q != COL_LAST) begin
              col_pos_d = col_pos_q + 1'b1;
            end
          end
        end
      end

      cmc_pkg::ST_DIV_COL: begin
        rem_d = rem_nxt;
        dvd_d = {dvd_q[cmc_pkg::SUM_W-2:0], take};
        if (step_q == cmc_pkg::DIV_LAST) begin
          cx_d    = {dvd_q[cmc_pkg::CEN_W-2:0], take};
          dvd_d   = row_sum_q;
          rem_d   = '0;
          step_d  = '0;
          state_d = cmc_pkg::ST_DIV_ROW;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      cmc_pkg::ST_DIV_ROW: begin
        rem_d = rem_nxt;
        dvd_d = {dvd_q[cmc_pkg::SUM_W-2:0], take};
        if (step_q == cmc_pkg::DIV_LAST) begin
          cy_d    = {dvd_q[cmc_pkg::CEN_W-2:0], take};
          state_d = cmc_pkg::ST_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      cmc_pkg::ST_DONE: begin
        if (out_free) begin
          // report the centroid and clear the frame state
          ovalid_d    = 1'b1;
          omask_d     = pend_mask_q;
          ocval_d     = 1'b1;
          ocol_d      = cnt_zero ? '0 : cx_q;
          orow_d      = cnt_zero ? '0 : cy_q;
          ocnt_d      = hit_count_q;
          col_sum_d   = '0;
          row_sum_d   = '0;
          hit_count_d = '0;
          col_pos_d   = '0;
          row_pos_d   = '0;
          state_d     = cmc_pkg::ST_RUN;
        end
      end

      default: state_d = cmc_pkg::ST_RUN;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cmc_pkg::ST_RUN;
      col_pos_q   <= '0;
      row_pos_q   <= '0;
      col_sum_q   <= '0;
      row_sum_q   <= '0;
      hit_count_q <= '0;
      step_q      <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_pos_q   <= col_pos_d;
      row_pos_q   <= row_pos_d;
      col_sum_q   <= col_sum_d;
      row_sum_q   <= row_sum_d;
      hit_count_q <= hit_count_d;
      step_q      <= step_d;
      ovalid_q    <= ovalid_d;
    end
  end

  // Payload: divider datapath and output fields
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    dvd_q       <= dvd_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    pend_mask_q <= pend_mask_d;
    omask_q     <= omask_d;
    ocval_q     <= ocval_d;
    ocol_q      <= ocol_d;
    orow_q      <= orow_d;
    ocnt_q      <= ocnt_d;
  end

  assign res_o.valid          = ovalid_q;
  assign res_o.mask_bit       = omask_q;
  assign res_o.centroid_valid = ocval_q;
  assign res_o.centroid_col   = ocol_q;
  assign res_o.centroid_row   = orow_q;
  assign res_o.match_count    = ocnt_q;

  `ASSERT_NEVER(a_busy_not_ready, (state_q != cmc_pkg::ST_RUN) && pix_i.ready)
  `ASSERT_PROP(a_eof_starts_div,
    (in_acc && pix_i.frame_end) |=> (state_q == cmc_pkg::ST_DIV_COL))
  `ASSERT_NEVER(a_step_bound, (step_q > cmc_pkg::DIV_LAST))
  `ASSERT_PROP(a_done_clears,
    ((state_q == cmc_pkg::ST_DONE) && out_free) |=>
      ((hit_count_q == '0) && (col_pos_q == '0) && (row_pos_q == '0) &&
       ovalid_q && ocval_q))

endmodule

`default_nettype wire
